>>> hdl/bba_pkg.sv
// Shared types and constants of the block bitmap allocator.
package bba_pkg;

  // Fixed field and bitmap word widths
  localparam int WORD_BITS = 64;
  localparam int WORD_LG   = 6;
  localparam int CNT_W     = 13;
  localparam int BLK_W     = 12;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int REG_W     = 32;

  // Register indexes (paddr[2])
  localparam logic [0:0] REG_TOTAL = 1'b0;
  localparam logic [0:0] REG_META  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_READ   = 2'd2,
    OP_FORMAT = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_FMT
  } state_t;

  // Configuration seen by the controller
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] meta;
  } cfg_t;

endpackage

>>> hdl/bba_ram.sv
// Bitmap word memory: one write port, one registered read port.
module bba_ram import bba_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [0:DEPTH-1];
  logic [WORD_BITS-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/bba_ctrl.sv
// Request sequencer: read-modify-write of bitmap words, full-word mask, free count.
module bba_ctrl import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 4096,
  parameter int NWORDS     = 64,
  parameter int WA_W       = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [BLK_W-1:0]     in_block_number,
  output logic                 out_valid,
  output logic [ST_W-1:0]      out_status,
  output logic [BLK_W-1:0]     out_result_block,
  output logic                 out_used_bit,
  output logic [CNT_W-1:0]     out_free_blocks,
  output logic                 ram_we,
  output logic [WA_W-1:0]      ram_waddr,
  output logic [WORD_BITS-1:0] ram_wdata,
  output logic [WA_W-1:0]      ram_raddr,
  input  logic [WORD_BITS-1:0] ram_rdata
);

  localparam int TOT_CAP    = (MAX_BLOCKS < 8191) ? MAX_BLOCKS : 8191;
  localparam int RESET_FREE = (MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096;
  localparam int IDX_W      = WA_W + WORD_LG;
  localparam int CW         = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  state_t               state_r, state_nxt;
  op_t                  op_r;
  logic [BLK_W-1:0]     blk_r;
  logic [WA_W-1:0]      wsel_r;
  logic                 anynf_r;
  logic [WA_W-1:0]      cnt_r;
  logic [CNT_W-1:0]     meta_r;
  logic                 rep_r;
  logic [CNT_W-1:0]     free_r;
  logic [NWORDS-1:0]    full_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [BLK_W-1:0]     out_blk_r;
  logic                 out_used_r;

  logic                 accept;
  logic [CNT_W-1:0]     tot;
  logic [CNT_W-1:0]     msat;
  logic [WA_W-1:0]      nf_idx;
  logic [WA_W-1:0]      blk_word;
  logic [WA_W-1:0]      rd_addr;
  logic [WORD_LG-1:0]   zidx;
  logic [IDX_W-1:0]     cand;
  logic                 alloc_ok;
  logic                 in_range;
  logic                 bit_sel;
  logic                 mod_we;
  logic [WORD_BITS-1:0] mod_wdata;
  logic                 last_word;
  logic [CW-1:0]        fill_m;
  logic [CW-1:0]        fill_lo;
  logic [CW-1:0]        fill_diff;
  logic                 fill_full;
  logic [WORD_BITS-1:0] fill_word;
  status_t              mod_status;
  logic [BLK_W-1:0]     mod_blk;
  logic                 mod_used;
  logic [CNT_W-1:0]     mod_free;

  function automatic logic [BLK_W-WORD_LG-1:0] blk_word_ext(input logic [BLK_W-1:0] b);
    blk_word_ext = b[BLK_W-1:WORD_LG];
  endfunction

  assign accept = start && (state_r == S_IDLE);

  // effective total and saturated metadata count
  assign tot  = (cfg.total > CNT_W'(TOT_CAP)) ? CNT_W'(TOT_CAP) : cfg.total;
  assign msat = (cfg.meta > tot) ? tot : cfg.meta;

  // lowest word that still has a clear bit
  always_comb begin
    nf_idx = '0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        nf_idx = WA_W'(i);
      end
    end
  end

  assign blk_word = WA_W'(blk_word_ext(in_block_number));
  assign rd_addr  = (op_t'(in_opcode) == OP_ALLOC) ? nf_idx : blk_word;

  // lowest clear bit of the word just read
  always_comb begin
    zidx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        zidx = WORD_LG'(i);
      end
    end
  end

  assign cand     = {wsel_r, zidx};
  assign alloc_ok = (free_r != '0) && anynf_r && (CW'(cand) < CW'(tot));
  assign in_range = CNT_W'(blk_r) < tot;
  assign bit_sel  = ram_rdata[blk_r[WORD_LG-1:0]];

  // modified word and result of a single-word request
  always_comb begin
    mod_we     = 1'b0;
    mod_wdata  = ram_rdata;
    mod_status = ST_OK;
    mod_blk    = blk_r;
    mod_used   = 1'b0;
    mod_free   = free_r;
    case (op_r)
      OP_ALLOC: begin
        mod_blk = '0;
        if (alloc_ok) begin
          mod_we    = 1'b1;
          mod_wdata = ram_rdata | (WORD_BITS'(1) << zidx);
          mod_blk   = BLK_W'(cand);
          mod_used  = 1'b1;
          mod_free  = free_r - 1'b1;
        end else begin
          mod_status = ST_NO_FREE;
        end
      end
      OP_FREE: begin
        if (!in_range) begin
          mod_status = ST_RANGE;
        end else if (!bit_sel) begin
          mod_status = ST_ALREADY_FREE;
        end else begin
          mod_we    = 1'b1;
          mod_wdata = ram_rdata & ~(WORD_BITS'(1) << blk_r[WORD_LG-1:0]);
          if (free_r < tot) begin
            mod_free = free_r + 1'b1;
          end
        end
      end
      OP_READ: begin
        if (!in_range) begin
          mod_status = ST_RANGE;
        end else begin
          mod_used = bit_sel;
        end
      end
      default: begin
        mod_blk = '0;
      end
    endcase
  end

  // format / clearing sweep word: bits of blocks below meta_r are set
  assign fill_m    = CW'(meta_r);
  assign fill_lo   = CW'({cnt_r, {WORD_LG{1'b0}}});
  assign fill_diff = fill_m - fill_lo;
  assign fill_full = fill_m >= (fill_lo + CW'(WORD_BITS));
  always_comb begin
    if (fill_full) begin
      fill_word = '1;
    end else if (fill_m > fill_lo) begin
      fill_word = (WORD_BITS'(1) << fill_diff[WORD_LG-1:0]) - 1'b1;
    end else begin
      fill_word = '0;
    end
  end

  assign last_word = (cnt_r == WA_W'(NWORDS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (op_t'(in_opcode) == OP_FORMAT) ? S_FMT : S_MOD;
        end
      end
      S_MOD:   state_nxt = S_IDLE;
      S_FMT: begin
        if (last_word) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = wsel_r;
    ram_wdata = mod_wdata;
    ram_raddr = rd_addr;
    unique case (state_r)
      S_IDLE: busy = 1'b0;
      S_MOD:  ram_we = mod_we;
      S_FMT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = fill_word;
      end
      default: busy = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FMT;
      cnt_r       <= '0;
      meta_r      <= '0;
      rep_r       <= 1'b0;
      free_r      <= CNT_W'(RESET_FREE);
      full_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (accept && (op_t'(in_opcode) == OP_FORMAT)) begin
            meta_r <= msat;
            cnt_r  <= '0;
            rep_r  <= 1'b1;
          end
        end
        S_MOD: begin
          out_valid_r <= 1'b1;
          free_r      <= mod_free;
          if (mod_we) begin
            full_r[wsel_r] <= &mod_wdata;
          end
        end
        S_FMT: begin
          full_r[cnt_r] <= fill_full;
          cnt_r         <= cnt_r + 1'b1;
          // only a requested format reports; the reset sweep stays silent
          out_valid_r   <= last_word && rep_r;
          if (last_word) begin
            rep_r <= 1'b0;
            if (rep_r) begin
              free_r <= tot - meta_r;
            end
          end
        end
        default: out_valid_r <= 1'b0;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_opcode);
      blk_r   <= in_block_number;
      wsel_r  <= rd_addr;
      anynf_r <= ~&full_r;
    end
    if (state_r == S_MOD) begin
      out_status_r <= mod_status;
      out_blk_r    <= mod_blk;
      out_used_r   <= mod_used;
    end else if (state_r == S_FMT) begin
      out_status_r <= ST_OK;
      out_blk_r    <= '0;
      out_used_r   <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_block = out_blk_r;
  assign out_used_bit     = out_used_r;
  assign out_free_blocks  = free_r;

`ifndef SYNTHESIS
  // a result only follows a modify cycle or the end of a format sweep
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_MOD || $past(state_r) == S_FMT))
    else $error("result strobe without a finishing request");

  // every accepted request leaves idle
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MOD || state_r == S_FMT))
    else $error("accepted request did not start");

  // a modify cycle always gives its result in the next cycle
  a_mod_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |=> (out_valid_r && state_r == S_IDLE))
    else $error("modify cycle gave no result");

  // the memory is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("bitmap write while idle");
`endif

endmodule

>>> hdl/block_bitmap_allocator.sv
// Top level of the block bitmap allocator: configuration registers and instances.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  request   | start, busy             | in_opcode, in_block_number
//  result    | out_valid (1-cycle)     | out_status, out_result_block,
//            |                         | out_used_bit, out_free_blocks
//  config    | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// Allocate, free and read fetch a bitmap word, then modify and write it back;
// the result strobe comes in the cycle after and busy is already low then.
// Format walks all NWORDS bitmap words, one per cycle, and the result strobe
// follows in the cycle after the last word.
// After reset the same sweep clears the memory and gives no result.
// Results cannot be held off; the next request may be accepted while a result shows.
module block_bitmap_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [OP_W-1:0]  in_opcode,
  input  logic [BLK_W-1:0] in_block_number,
  output logic             out_valid,
  output logic [ST_W-1:0]  out_status,
  output logic [BLK_W-1:0] out_result_block,
  output logic             out_used_bit,
  output logic [CNT_W-1:0] out_free_blocks,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [REG_W-1:0] pwdata,
  output logic [REG_W-1:0] prdata,
  output logic             pready
);

  localparam int NWORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  logic [CNT_W-1:0]     total_r;
  logic [CNT_W-1:0]     meta_r;
  logic                 wr_en;
  cfg_t                 cfg;
  logic                 ram_we;
  logic [WA_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WA_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= CNT_W'(4096);
      meta_r  <= '0;
    end else if (wr_en) begin
      unique case (paddr[2:2])
        REG_TOTAL: total_r <= pwdata[CNT_W-1:0];
        REG_META:  meta_r  <= pwdata[CNT_W-1:0];
        default:   total_r <= total_r;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[2:2])
      REG_TOTAL: prdata = REG_W'(total_r);
      REG_META:  prdata = REG_W'(meta_r);
      default:   prdata = '0;
    endcase
  end

  assign cfg.total = total_r;
  assign cfg.meta  = meta_r;

  bba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .NWORDS     (NWORDS),
    .WA_W       (WA_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_block_number  (in_block_number),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_block (out_result_block),
    .out_used_bit     (out_used_bit),
    .out_free_blocks  (out_free_blocks),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  bba_ram #(
    .DEPTH (NWORDS),
    .AW    (WA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> tb/bba_checker.sv
// Allocator reply checker: tracks every request and register write, predicts the reply, compares.
module bba_checker import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [OP_W-1:0]  in_opcode,
  input  logic [BLK_W-1:0] in_block_number,
  input  logic             out_valid,
  input  logic [ST_W-1:0]  out_status,
  input  logic [BLK_W-1:0] out_result_block,
  input  logic             out_used_bit,
  input  logic [CNT_W-1:0] out_free_blocks,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [REG_W-1:0] pwdata,
  input  logic             pready,
  output int               fails,
  output int               pending,
  output int               replies_checked
);

  localparam int MAX_BLK = 4096;
  localparam int NWORDS  = MAX_BLK / WORD_BITS;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] blk;
    logic             used;
    logic [CNT_W-1:0] free_cnt;
  } reply_t;

  // Shadow allocator state
  logic [WORD_BITS-1:0] usage_words [NWORDS];
  logic [CNT_W-1:0]     free_cnt;
  logic [CNT_W-1:0]     total_reg;
  logic [CNT_W-1:0]     meta_reg;
  reply_t               replies_due [$];

  // Totals above the bitmap size saturate
  function automatic logic [CNT_W-1:0] tracked_total();
    return (total_reg > CNT_W'(MAX_BLK)) ? CNT_W'(MAX_BLK) : total_reg;
  endfunction

  // Apply one request to the shadow state and return the reply it should give
  function automatic reply_t apply_request(op_t op, logic [BLK_W-1:0] blk);
    reply_t           r;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] marked;
    int               w;
    int               i;
    int               cand;
    bit               found;
    lim   = tracked_total();
    r     = '0;
    found = 1'b0;
    cand  = 0;
    case (op)
      OP_ALLOC: begin
        // first clear bit anywhere in the bitmap, then checked against the total
        if (free_cnt != '0) begin
          for (w = 0; w < NWORDS && !found; w++) begin
            if (usage_words[w] != '1) begin
              for (i = 0; i < WORD_BITS && !found; i++) begin
                if (!usage_words[w][i]) begin
                  found = 1'b1;
                  cand  = w * WORD_BITS + i;
                end
              end
            end
          end
        end
        if (found && cand < int'(lim)) begin
          usage_words[cand / WORD_BITS][cand % WORD_BITS] = 1'b1;
          free_cnt = free_cnt - 1'b1;
          r.blk    = BLK_W'(cand);
          r.used   = 1'b1;
        end else begin
          r.status = ST_NO_FREE;
        end
      end
      OP_FREE, OP_READ: begin
        r.blk = blk;
        if ({1'b0, blk} >= lim) begin
          r.status = ST_RANGE;
        end else if (op == OP_READ) begin
          r.used = usage_words[blk[BLK_W-1:WORD_LG]][blk[WORD_LG-1:0]];
        end else if (!usage_words[blk[BLK_W-1:WORD_LG]][blk[WORD_LG-1:0]]) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          usage_words[blk[BLK_W-1:WORD_LG]][blk[WORD_LG-1:0]] = 1'b0;
          if (free_cnt < lim) free_cnt = free_cnt + 1'b1;
        end
      end
      default: begin
        // format: clear, then mark the leading metadata blocks
        marked = (meta_reg > lim) ? lim : meta_reg;
        for (w = 0; w < NWORDS; w++) usage_words[w] = '0;
        for (i = 0; i < int'(marked); i++) usage_words[i / WORD_BITS][i % WORD_BITS] = 1'b1;
        free_cnt = lim - marked;
      end
    endcase
    r.free_cnt = free_cnt;
    return r;
  endfunction

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int w = 0; w < NWORDS; w++) usage_words[w] = '0;
      free_cnt  = CNT_W'(MAX_BLK);
      total_reg = CNT_W'(MAX_BLK);
      meta_reg  = '0;
      replies_due.delete();
    end else begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          $error("reply with no request outstanding: status %0d block %0d",
                 out_status, out_result_block);
          fails++;
        end else begin
          want = replies_due.pop_front();
          replies_checked++;
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
          if (out_result_block !== want.blk) begin
            $error("result_block: expected %0d, got %0d", want.blk, out_result_block);
            fails++;
          end
          if (out_used_bit !== want.used) begin
            $error("used_bit: expected %0d, got %0d", want.used, out_used_bit);
            fails++;
          end
          if (out_free_blocks !== want.free_cnt) begin
            $error("free_blocks: expected %0d, got %0d", want.free_cnt, out_free_blocks);
            fails++;
          end
        end
      end
      // register write completes in the access phase
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TOTAL) total_reg = pwdata[CNT_W-1:0];
        else                       meta_reg  = pwdata[CNT_W-1:0];
      end
      if (start && !busy) replies_due.push_back(apply_request(op_t'(in_opcode), in_block_number));
      pending = replies_due.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench top for the block bitmap allocator: clock, reset, request stimulus and verdict.
module tb_top;
  import bba_pkg::*;

  localparam int MAX_BLK     = 4096;
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 127;

  // register settings per random phase: small totals fill up, extremes saturate
  localparam int PHASE_TOTAL [N_PHASES] =
    '{4096, 64, 1, 200, 65, 8191, 130, 4096, 3, 1000, 0, 100};
  localparam int PHASE_META  [N_PHASES] =
    '{0, 10, 0, 4096, 64, 8191, 129, 4000, 1, 0, 5, 40};

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             start           = 1'b0;
  logic [OP_W-1:0]  in_opcode       = '0;
  logic [BLK_W-1:0] in_block_number = '0;
  logic             psel            = 1'b0;
  logic             penable         = 1'b0;
  logic             pwrite          = 1'b0;
  logic [2:0]       paddr           = '0;
  logic [REG_W-1:0] pwdata          = '0;
  logic             busy;
  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [BLK_W-1:0] out_result_block;
  logic             out_used_bit;
  logic [CNT_W-1:0] out_free_blocks;
  logic [REG_W-1:0] prdata;
  logic             pready;

  int fails;
  int pending;
  int replies_checked;
  int n_sent;
  int n_formats;
  int n_settings;
  int cur_limit = MAX_BLK;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  block_bitmap_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_block_number  (in_block_number),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_block (out_result_block),
    .out_used_bit     (out_used_bit),
    .out_free_blocks  (out_free_blocks),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  bba_checker u_reply_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_block_number  (in_block_number),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_block (out_result_block),
    .out_used_bit     (out_used_bit),
    .out_free_blocks  (out_free_blocks),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fails            (fails),
    .pending          (pending),
    .replies_checked  (replies_checked)
  );

  // Present a request and hold it until accepted; start stays high afterwards
  task automatic send(op_t op, logic [BLK_W-1:0] blk);
    in_opcode       <= op;
    in_block_number <= blk;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    n_sent++;
    if (op == OP_FORMAT) n_formats++;
  endtask

  task automatic idle_gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Stop requesting and wait until every reply is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Setup then access phase; the bus is released by the caller
  task automatic reg_write(logic [0:0] idx, logic [CNT_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(REG_W-CNT_W)'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_limits(logic [CNT_W-1:0] total, logic [CNT_W-1:0] meta);
    reg_write(REG_TOTAL, total);
    reg_write(REG_META, meta);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    cur_limit = (total > MAX_BLK) ? MAX_BLK : int'(total);
    n_settings++;
  endtask

  // Random requests after a format; block numbers lean towards the tracked range
  task automatic run_batch(int count, bit gaps);
    op_t              op;
    logic [BLK_W-1:0] blk;
    int               roll;
    send(OP_FORMAT, BLK_W'($urandom));
    for (int k = 1; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      op = OP_ALLOC;
      else if (roll < 75) op = OP_FREE;
      else if (roll < 97) op = OP_READ;
      else                op = OP_FORMAT;
      roll = $urandom_range(0, 9);
      if (roll < 6)      blk = BLK_W'($urandom_range(0, (cur_limit > 0) ? cur_limit - 1 : 0));
      else if (roll < 8) blk = BLK_W'($urandom_range(0, 63));
      else               blk = BLK_W'($urandom);
      if (gaps && $urandom_range(0, 3) == 0) idle_gap();
      send(op, blk);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: reads, first-fit, double free, format with no metadata
    send(OP_READ, 12'd0);
    send(OP_READ, 12'd4095);
    send(OP_ALLOC, 12'd0);
    send(OP_ALLOC, 12'd0);
    send(OP_FREE, 12'd1);
    send(OP_FREE, 12'd1);
    send(OP_FREE, 12'd4095);
    send(OP_READ, 12'd0);
    send(OP_FORMAT, 12'd0);

    // tiny disk: metadata reserved, exhaustion, out of range, freeing metadata
    drain();
    set_limits(13'd5, 13'd2);
    send(OP_FORMAT, 12'd4095);
    send(OP_ALLOC, 12'd0);
    send(OP_ALLOC, 12'd0);
    send(OP_ALLOC, 12'd0);
    send(OP_ALLOC, 12'd0);
    send(OP_FREE, 12'd5);
    send(OP_READ, 12'd4095);
    send(OP_FREE, 12'd0);
    send(OP_ALLOC, 12'd0);

    // zero total: nothing allocatable, everything out of range
    drain();
    set_limits(13'd0, 13'd2);
    send(OP_ALLOC, 12'd0);
    send(OP_READ, 12'd0);
    send(OP_FORMAT, 12'd0);

    // oversized total and metadata saturate: fully used bitmap
    drain();
    set_limits(13'd8191, 13'd8191);
    send(OP_FORMAT, 12'd0);
    send(OP_ALLOC, 12'd0);
    send(OP_FREE, 12'd4095);
    send(OP_ALLOC, 12'd0);
    send(OP_FREE, 12'd100);

    // total shrunk below the only free block: count nonzero but allocate fails
    drain();
    set_limits(13'd50, 13'd0);
    send(OP_ALLOC, 12'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      set_limits(CNT_W'(PHASE_TOTAL[p]), CNT_W'(PHASE_META[p]));
      run_batch(PHASE_ITEMS, (p < N_PHASES - 1) && ($urandom_range(0, 3) != 0));
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d requests (%0d formats) over %0d register settings",
             n_sent, n_formats, n_settings);
    $display("%0d replies compared, %0d mismatches", replies_checked, fails);
    if (fails == 0 && pending == 0) begin
      $display("block_bitmap_allocator verification clean");
    end else begin
      $display("block_bitmap_allocator verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("block_bitmap_allocator verification failed");
    $finish;
  end

endmodule

>>> files.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_ctrl.sv
hdl/block_bitmap_allocator.sv
tb/bba_checker.sv
tb/tb_top.sv
